// ===== src/vqdm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vqdm_pkg
// Shared constants, codes and types of the split-virtqueue descriptor engine.
// ---------------------------------------------------------------------------
package vqdm_pkg;

  localparam int unsigned QUEUE_DEPTH = 256;
  localparam int unsigned AW          = $clog2(QUEUE_DEPTH);
  localparam int unsigned SIZE_W      = AW + 1;

  localparam logic [15:0] LIST_END = 16'hFFFF;

  localparam logic [1:0] CFG_REQ_SIZE  = 2'd0;
  localparam logic [1:0] CFG_DEV_MAX   = 2'd1;
  localparam logic [1:0] CFG_QUEUE_NUM = 2'd2;

  typedef enum logic [2:0] {
    ACT_INIT   = 3'd0,
    ACT_ALLOC  = 3'd1,
    ACT_FREE   = 3'd2,
    ACT_FILL   = 3'd3,
    ACT_SUBMIT = 3'd4,
    ACT_POLL   = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_ABSENT    = 2'd2,
    ST_SIZE_ZERO = 2'd3
  } status_e;

  // Table write commands, one write port per store
  typedef struct packed {
    logic          link_we;
    logic [AW-1:0] link_addr;
    logic [15:0]   link_data;
    logic          desc_we;
    logic [AW-1:0] desc_addr;
    logic [63:0]   desc_buf_addr;
    logic [31:0]   desc_buf_len;
    logic          flag_we;
    logic [AW-1:0] flag_addr;
    logic [1:0]    flag_data;
    logic          avail_we;
    logic [AW-1:0] avail_addr;
    logic [7:0]    avail_data;
  } tbl_wr_t;

  // Init sweep status
  typedef struct packed {
    logic          active;
    logic          last;
    logic          in_range;
    logic [AW-1:0] addr;
    logic [15:0]   link;
  } sweep_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] got_entry;
    logic        notify;
    logic [15:0] notify_queue;
    logic [7:0]  avail_slot;
    logic [15:0] avail_count;
    logic        new_used;
    logic [8:0]  size_out;
  } result_t;

  // Largest power of two not above v (v is nonzero where it matters)
  function automatic logic [SIZE_W-1:0] floor_pow2(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) begin
        r = SIZE_W'(1) << i;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/vqdm_sweep.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vqdm_sweep
// Init walker: steps over every table entry once, building the free list
// links for entries below the new queue size.
// ---------------------------------------------------------------------------
module vqdm_sweep (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [vqdm_pkg::SIZE_W-1:0]   size_i,
  output vqdm_pkg::sweep_t              sweep_o
);

  logic                        active_q, active_d;
  logic [vqdm_pkg::AW-1:0]     cnt_q, cnt_d;
  logic                        last;
  logic [vqdm_pkg::SIZE_W-1:0] cur_ext;
  logic [vqdm_pkg::SIZE_W-1:0] nxt_ext;

  assign last    = active_q && (cnt_q == vqdm_pkg::AW'(vqdm_pkg::QUEUE_DEPTH - 1));
  assign cur_ext = {1'b0, cnt_q};
  assign nxt_ext = cur_ext + 1'b1;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
    end else if (active_q) begin
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  always_comb begin
    sweep_o          = '0;
    sweep_o.active   = active_q;
    sweep_o.last     = last;
    sweep_o.addr     = cnt_q;
    sweep_o.in_range = active_q && (cur_ext < size_i);
    // last entry of the queue closes the free list
    sweep_o.link     = (nxt_ext < size_i) ? 16'(nxt_ext) : vqdm_pkg::LIST_END;
  end

endmodule
`default_nettype wire

// ===== src/vqdm_tables.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vqdm_tables
// Descriptor stores: link, buffer address/length, flags and avail ring.
// One write port each; the link store has a registered read port.
// ---------------------------------------------------------------------------
module vqdm_tables (
  input  logic                    clk_i,
  input  vqdm_pkg::tbl_wr_t       wr_i,
  input  logic [vqdm_pkg::AW-1:0] link_raddr_i,
  output logic [15:0]             link_rdata_o
);

  logic [15:0] link_mem  [vqdm_pkg::QUEUE_DEPTH];
  logic [95:0] desc_mem  [vqdm_pkg::QUEUE_DEPTH];
  logic [1:0]  flag_mem  [vqdm_pkg::QUEUE_DEPTH];
  logic [7:0]  avail_mem [vqdm_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.link_we) begin
      link_mem[wr_i.link_addr] <= wr_i.link_data;
    end
    link_rdata_o <= link_mem[link_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.desc_we) begin
      desc_mem[wr_i.desc_addr] <= {wr_i.desc_buf_addr, wr_i.desc_buf_len};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.flag_we) begin
      flag_mem[wr_i.flag_addr] <= wr_i.flag_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.avail_we) begin
      avail_mem[wr_i.avail_addr] <= wr_i.avail_data;
    end
  end

endmodule
`default_nettype wire

// ===== src/virtqueue_descriptor_manager_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// virtqueue_descriptor_manager_core
// Driver-side split-virtqueue engine: free list, descriptor fill, avail ring.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i/in_ready_o) carries one action per
//   transaction; every request yields exactly one response on the result
//   channel (out_valid_o/out_ready_i). The config channel writes the
//   requested size, device maximum and queue number; it is always ready.
//   Free, fill, submit, poll: decode and table write, then hand-off to the
//   output register. Alloc adds the S_ALLOC state for the registered read
//   of the link table at the free-list head.
//   A successful init walks all QUEUE_DEPTH entries once, one per cycle.
//   The response moves into the output register once that register is free;
//   a new request is taken while that response waits. If the
//   receiver stalls, the next finished response holds in the engine and
//   in_ready_o stays low until the output register frees up.
//   Reset empties the free list, zeroes counters and size, and loads the
//   config defaults (256, 256, 0). The link table holds no valid data until
//   the first init; no clearing pass runs after reset.
// ---------------------------------------------------------------------------
module virtqueue_descriptor_manager_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [7:0]  entry_index_i,
  input  logic [63:0] buf_addr_i,
  input  logic [31:0] buf_len_i,
  input  logic        device_writes_i,
  input  logic        chained_i,
  input  logic [7:0]  next_entry_i,
  input  logic [15:0] used_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] got_entry_o,
  output logic        notify_o,
  output logic [15:0] notify_queue_o,
  output logic [7:0]  avail_slot_o,
  output logic [15:0] avail_count_o,
  output logic        new_used_o,
  output logic [8:0]  size_in_use_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_SWEEP,
    S_HOLD
  } state_e;

  state_e                      state_q, state_d;
  logic [15:0]                 req_q, req_d;
  logic [15:0]                 dev_q, dev_d;
  logic [15:0]                 qnum_q, qnum_d;
  logic [15:0]                 free_head_q, free_head_d;
  logic [15:0]                 avail_cnt_q, avail_cnt_d;
  logic [15:0]                 used_seen_q, used_seen_d;
  logic [vqdm_pkg::SIZE_W-1:0] size_q, size_d;
  vqdm_pkg::result_t           res_q, res_d, res_n;
  vqdm_pkg::result_t           out_q, out_d;
  logic                        out_valid_q, out_valid_d;

  logic                        load_res;
  logic                        out_load;
  logic                        sweep_start;
  vqdm_pkg::sweep_t            sweep;
  vqdm_pkg::tbl_wr_t           wr;
  logic [15:0]                 link_rdata;

  logic [15:0]                 idx16;
  logic [vqdm_pkg::AW-1:0]     idx_a;
  logic                        in_queue;
  logic [15:0]                 min_rd;
  logic [15:0]                 clamp16;
  logic [vqdm_pkg::SIZE_W-1:0] init_size;
  logic [vqdm_pkg::SIZE_W-1:0] size_m1;
  logic [vqdm_pkg::AW-1:0]     slot;
  logic                        head_empty;

  vqdm_sweep u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sweep_start),
    .size_i  (size_q),
    .sweep_o (sweep)
  );

  vqdm_tables u_tables (
    .clk_i        (clk_i),
    .wr_i         (wr),
    .link_raddr_i (free_head_q[vqdm_pkg::AW-1:0]),
    .link_rdata_o (link_rdata)
  );

  assign idx16    = 16'(entry_index_i);
  assign idx_a    = idx16[vqdm_pkg::AW-1:0];
  assign in_queue = idx16 < 16'(size_q);

  // clamp to device and local depth, then round down to a power of two
  assign min_rd    = (req_q < dev_q) ? req_q : dev_q;
  assign clamp16   = (min_rd > 16'(vqdm_pkg::QUEUE_DEPTH)) ? 16'(vqdm_pkg::QUEUE_DEPTH) : min_rd;
  assign init_size = vqdm_pkg::floor_pow2(clamp16[vqdm_pkg::SIZE_W-1:0]);

  assign size_m1    = size_q - 1'b1;
  assign slot       = avail_cnt_q[vqdm_pkg::AW-1:0] & size_m1[vqdm_pkg::AW-1:0];
  assign head_empty = (free_head_q == vqdm_pkg::LIST_END) ||
                      (free_head_q >= 16'(vqdm_pkg::QUEUE_DEPTH));

  assign out_load = (state_q == S_HOLD) && (!out_valid_q || out_ready_i);

  always_comb begin
    req_d  = req_q;
    dev_d  = dev_q;
    qnum_d = qnum_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        vqdm_pkg::CFG_REQ_SIZE:  req_d  = cfg_data_i;
        vqdm_pkg::CFG_DEV_MAX:   dev_d  = cfg_data_i;
        vqdm_pkg::CFG_QUEUE_NUM: qnum_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    free_head_d = free_head_q;
    avail_cnt_d = avail_cnt_q;
    used_seen_d = used_seen_q;
    size_d      = size_q;
    res_n       = '0;
    load_res    = 1'b0;
    sweep_start = 1'b0;
    wr          = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (vqdm_pkg::action_e'(action_i))
            vqdm_pkg::ACT_INIT: begin
              if (dev_q == 16'd0) begin
                res_n.status   = vqdm_pkg::ST_ABSENT;
                res_n.size_out = 9'(size_q);
                load_res       = 1'b1;
                state_d        = S_HOLD;
              end else if (init_size == '0) begin
                res_n.status   = vqdm_pkg::ST_SIZE_ZERO;
                res_n.size_out = 9'(size_q);
                load_res       = 1'b1;
                state_d        = S_HOLD;
              end else begin
                free_head_d = '0;
                avail_cnt_d = '0;
                used_seen_d = '0;
                size_d      = init_size;
                sweep_start = 1'b1;
                state_d     = S_SWEEP;
              end
            end
            vqdm_pkg::ACT_ALLOC: begin
              state_d = S_ALLOC;
            end
            vqdm_pkg::ACT_FREE: begin
              if (in_queue) begin
                wr.link_we   = 1'b1;
                wr.link_addr = idx_a;
                wr.link_data = free_head_q;
                wr.flag_we   = 1'b1;
                wr.flag_addr = idx_a;
                wr.flag_data = 2'b00;
                free_head_d  = idx16;
              end
              load_res = 1'b1;
              state_d  = S_HOLD;
            end
            vqdm_pkg::ACT_FILL: begin
              if (in_queue) begin
                wr.desc_we       = 1'b1;
                wr.desc_addr     = idx_a;
                wr.desc_buf_addr = buf_addr_i;
                wr.desc_buf_len  = buf_len_i;
                wr.flag_we       = 1'b1;
                wr.flag_addr     = idx_a;
                wr.flag_data     = {device_writes_i, chained_i};
                wr.link_we       = 1'b1;
                wr.link_addr     = idx_a;
                wr.link_data     = chained_i ? 16'(next_entry_i) : 16'd0;
              end
              load_res = 1'b1;
              state_d  = S_HOLD;
            end
            vqdm_pkg::ACT_SUBMIT: begin
              if (in_queue) begin
                wr.avail_we        = 1'b1;
                wr.avail_addr      = slot;
                wr.avail_data      = entry_index_i;
                avail_cnt_d        = avail_cnt_q + 16'd1;
                res_n.notify       = 1'b1;
                res_n.notify_queue = qnum_q;
                res_n.avail_slot   = 8'(slot);
              end
              load_res = 1'b1;
              state_d  = S_HOLD;
            end
            vqdm_pkg::ACT_POLL: begin
              if (used_index_i != used_seen_q) begin
                res_n.new_used = 1'b1;
                used_seen_d    = used_index_i;
              end
              load_res = 1'b1;
              state_d  = S_HOLD;
            end
            default: begin
              load_res = 1'b1;
              state_d  = S_HOLD;
            end
          endcase
        end
      end
      S_ALLOC: begin
        // link data for the head was read at the accepting edge
        if (head_empty) begin
          res_n.status    = vqdm_pkg::ST_NO_FREE;
          res_n.got_entry = vqdm_pkg::LIST_END;
        end else begin
          res_n.got_entry = free_head_q;
          free_head_d     = link_rdata;
        end
        load_res = 1'b1;
        state_d  = S_HOLD;
      end
      S_SWEEP: begin
        wr.link_we       = sweep.in_range;
        wr.link_addr     = sweep.addr;
        wr.link_data     = sweep.link;
        wr.desc_we       = sweep.in_range;
        wr.desc_addr     = sweep.addr;
        wr.desc_buf_addr = '0;
        wr.desc_buf_len  = '0;
        wr.flag_we       = sweep.in_range;
        wr.flag_addr     = sweep.addr;
        wr.flag_data     = 2'b00;
        wr.avail_we      = sweep.active;
        wr.avail_addr    = sweep.addr;
        wr.avail_data    = '0;
        if (sweep.last) begin
          res_n.size_out = 9'(size_q);
          load_res       = 1'b1;
          state_d        = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load_res) begin
      res_n.avail_count = avail_cnt_d;
    end
  end

  assign res_d       = load_res ? res_n : res_q;
  assign out_d       = out_load ? res_q : out_q;
  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= 16'd256;
      dev_q       <= 16'd256;
      qnum_q      <= 16'd0;
      free_head_q <= vqdm_pkg::LIST_END;
      avail_cnt_q <= '0;
      used_seen_q <= '0;
      size_q      <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      dev_q       <= dev_d;
      qnum_q      <= qnum_d;
      free_head_q <= free_head_d;
      avail_cnt_q <= avail_cnt_d;
      used_seen_q <= used_seen_d;
      size_q      <= size_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign got_entry_o       = out_q.got_entry;
  assign notify_o          = out_q.notify;
  assign notify_queue_o    = out_q.notify_queue;
  assign avail_slot_o      = out_q.avail_slot;
  assign avail_count_o     = out_q.avail_count;
  assign new_used_o        = out_q.new_used;
  assign size_in_use_out_o = out_q.size_out;

endmodule
`default_nettype wire

// ===== src/vqdm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vqdm_checker
// Port-level checks of the descriptor engine, bound to the top level.
// ---------------------------------------------------------------------------
module vqdm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [15:0] got_entry_o,
  input logic        notify_o,
  input logic [15:0] notify_queue_o,
  input logic [7:0]  avail_slot_o
);

  // a waiting response stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("response dropped while stalled");

  // engine is not ready in the cycle after it takes a request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken on consecutive cycles");

  a_notify_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && notify_o |-> (status_o == vqdm_pkg::ST_OK) && (got_entry_o == 16'd0))
    else $error("notify with bad status or entry");

  a_no_free_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == vqdm_pkg::ST_NO_FREE) |-> (got_entry_o == 16'hFFFF))
    else $error("empty free list without end marker");

  a_quiet_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !notify_o |-> (notify_queue_o == 16'd0) && (avail_slot_o == 8'd0))
    else $error("queue fields set without notify");

endmodule

bind virtqueue_descriptor_manager_core vqdm_checker u_vqdm_checker (.*);
`default_nettype wire

// ===== test/virtqueue_descriptor_manager_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// virtqueue_descriptor_manager_core_tb
// Self-checking bench for the split-virtqueue descriptor engine. A shadow of
// the free list, avail counter, used index and queue size predicts each
// response; directed requests hit the corner cases, then chained
// alloc/fill/submit/poll traffic mixed with noise runs under several queue
// configurations with random input gaps and output stalls.
// ---------------------------------------------------------------------------
module virtqueue_descriptor_manager_core_tb;

  localparam logic [2:0] ACT_RSVD_6 = 3'd6;
  localparam logic [2:0] ACT_RSVD_7 = 3'd7;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 400;

  typedef struct {
    logic [2:0]  action;
    logic [7:0]  entry_index;
    logic [63:0] buf_addr;
    logic [31:0] buf_len;
    logic        device_writes;
    logic        chained;
    logic [7:0]  next_entry;
    logic [15:0] used_index;
  } request_t;

  // Shadow of the descriptor engine plus the queue of pending responses
  class descriptor_shadow;
    logic [15:0] link_mem [vqdm_pkg::QUEUE_DEPTH];
    logic [15:0] free_head = vqdm_pkg::LIST_END;
    logic [15:0] avail_cnt = '0;
    logic [15:0] used_last = '0;
    int unsigned qsize = 0;
    logic [15:0] req_size = 16'd256;
    logic [15:0] dev_max = 16'd256;
    logic [15:0] queue_num = '0;
    logic [15:0] last_got;
    bit          last_effective;
    int unsigned mismatches = 0;
    int unsigned checked = 0;
    vqdm_pkg::result_t expected_responses [$];

    function void set_register(logic [1:0] idx, logic [15:0] data);
      case (idx)
        vqdm_pkg::CFG_REQ_SIZE:  req_size = data;
        vqdm_pkg::CFG_DEV_MAX:   dev_max = data;
        vqdm_pkg::CFG_QUEUE_NUM: queue_num = data;
        default: ;
      endcase
    endfunction

    function vqdm_pkg::result_t predict_response(request_t r);
      vqdm_pkg::result_t e;
      int unsigned n;
      int unsigned p;
      bit          in_range;
      e = '0;
      e.status = vqdm_pkg::ST_OK;
      in_range = r.entry_index < qsize;
      last_effective = 1'b1;
      case (r.action)
        vqdm_pkg::ACT_INIT: begin
          if (dev_max == 0) begin
            e.status = vqdm_pkg::ST_ABSENT;
          end else begin
            n = (req_size < dev_max) ? req_size : dev_max;
            if (n > vqdm_pkg::QUEUE_DEPTH) n = vqdm_pkg::QUEUE_DEPTH;
            if (n == 0) begin
              e.status = vqdm_pkg::ST_SIZE_ZERO;
            end else begin
              p = 1;
              while (p * 2 <= n) p = p * 2;
              for (int i = 0; i < p; i++) begin
                link_mem[i] = (i + 1 < p) ? 16'(i + 1) : vqdm_pkg::LIST_END;
              end
              free_head = '0;
              avail_cnt = '0;
              used_last = '0;
              qsize = p;
            end
          end
          e.size_out = 9'(qsize);
        end
        vqdm_pkg::ACT_ALLOC: begin
          if (free_head == vqdm_pkg::LIST_END || free_head >= vqdm_pkg::QUEUE_DEPTH) begin
            e.status = vqdm_pkg::ST_NO_FREE;
            e.got_entry = vqdm_pkg::LIST_END;
          end else begin
            e.got_entry = free_head;
            free_head = link_mem[free_head[7:0]];
          end
          last_got = e.got_entry;
        end
        vqdm_pkg::ACT_FREE: begin
          last_effective = in_range;
          if (in_range) begin
            link_mem[r.entry_index] = free_head;
            free_head = {8'h00, r.entry_index};
          end
        end
        vqdm_pkg::ACT_FILL: begin
          last_effective = in_range;
          if (in_range) link_mem[r.entry_index] = r.chained ? {8'h00, r.next_entry} : '0;
        end
        vqdm_pkg::ACT_SUBMIT: begin
          last_effective = in_range;
          if (in_range) begin
            e.avail_slot = 8'(avail_cnt & 16'(qsize - 1));
            avail_cnt = avail_cnt + 16'd1;
            e.notify = 1'b1;
            e.notify_queue = queue_num;
          end
        end
        vqdm_pkg::ACT_POLL: begin
          if (r.used_index != used_last) begin
            e.new_used = 1'b1;
            used_last = r.used_index;
          end
        end
        default: last_effective = 1'b0;
      endcase
      e.avail_count = avail_cnt;
      return e;
    endfunction

    function void note_request(request_t r);
      expected_responses.push_back(predict_response(r));
    endfunction

    function void compare_field(string name, logic [63:0] e, logic [63:0] a,
                                inout string diff);
      if (a !== e) diff = {diff, $sformatf(" %s exp %0h got %0h", name, e, a)};
    endfunction

    function void check_response(vqdm_pkg::result_t a);
      vqdm_pkg::result_t e;
      string   diff;
      checked++;
      if (expected_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("response %0d arrived with none pending", checked);
        return;
      end
      e = expected_responses.pop_front();
      diff = "";
      compare_field("status", 64'(e.status), 64'(a.status), diff);
      compare_field("got_entry", 64'(e.got_entry), 64'(a.got_entry), diff);
      compare_field("notify", 64'(e.notify), 64'(a.notify), diff);
      compare_field("notify_queue", 64'(e.notify_queue), 64'(a.notify_queue), diff);
      compare_field("avail_slot", 64'(e.avail_slot), 64'(a.avail_slot), diff);
      compare_field("avail_count", 64'(e.avail_count), 64'(a.avail_count), diff);
      compare_field("new_used", 64'(e.new_used), 64'(a.new_used), diff);
      compare_field("size_in_use", 64'(e.size_out), 64'(a.size_out), diff);
      if (diff != "") begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch on response %0d:%s", checked, diff);
      end
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  action_i;
  logic [7:0]  entry_index_i;
  logic [63:0] buf_addr_i;
  logic [31:0] buf_len_i;
  logic        device_writes_i;
  logic        chained_i;
  logic [7:0]  next_entry_i;
  logic [15:0] used_index_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [15:0] got_entry_o;
  logic        notify_o;
  logic [15:0] notify_queue_o;
  logic [7:0]  avail_slot_o;
  logic [15:0] avail_count_o;
  logic        new_used_o;
  logic [8:0]  size_in_use_out_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  virtqueue_descriptor_manager_core uut (.*);

  always #5 clk_i = ~clk_i;

  descriptor_shadow shadow = new;
  bit               running = 1'b0;
  bit               hold_req = 1'b0;
  int unsigned      idle_cycles = 0;
  int unsigned      burst_left = 0;
  int unsigned      useful_requests = 0;
  logic [15:0]      used_ctr = '0;

  // Response monitor and watchdog
  always @(posedge clk_i) begin
    vqdm_pkg::result_t got;
    if (running) begin
      if (out_valid_o && out_ready_i) begin
        got.status       = vqdm_pkg::status_e'(status_o);
        got.got_entry    = got_entry_o;
        got.notify       = notify_o;
        got.notify_queue = notify_queue_o;
        got.avail_slot   = avail_slot_o;
        got.avail_count  = avail_count_o;
        got.new_used     = new_used_o;
        got.size_out     = size_in_use_out_o;
        shadow.check_response(got);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver: stall patterns that change every so often, plus long hold-offs on request
  initial begin
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned mode;
    hold_left = 0;
    mode_left = 0;
    mode = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= (mode_left % 4 == 0);
          default: out_ready_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic request_t req_of(logic [2:0] act, logic [7:0] idx);
    request_t r;
    r.action = act;
    r.entry_index = idx;
    r.buf_addr = '0;
    r.buf_len = '0;
    r.device_writes = 1'b0;
    r.chained = 1'b0;
    r.next_entry = '0;
    r.used_index = '0;
    return r;
  endfunction

  // Called at a falling edge; returns at a falling edge with valid possibly still high
  task automatic send_request(request_t r);
    action_i        <= r.action;
    entry_index_i   <= r.entry_index;
    buf_addr_i      <= r.buf_addr;
    buf_len_i       <= r.buf_len;
    device_writes_i <= r.device_writes;
    chained_i       <= r.chained;
    next_entry_i    <= r.next_entry;
    used_index_i    <= r.used_index;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    shadow.note_request(r);
    if (shadow.last_effective) useful_requests++;
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
    end
  endtask

  // Hold the sender until every pending response is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (shadow.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow.set_register(idx, data);
    @(negedge clk_i);
  endtask

  task automatic program_queue(logic [15:0] req, logic [15:0] dev, logic [15:0] qn);
    write_register(vqdm_pkg::CFG_REQ_SIZE, req);
    write_register(vqdm_pkg::CFG_DEV_MAX, dev);
    write_register(vqdm_pkg::CFG_QUEUE_NUM, qn);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_index();
    if (shadow.qsize > 0 && $urandom_range(0, 2) != 0) return 8'($urandom_range(0, shadow.qsize - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_noise();
    request_t r;
    r.action = 3'($urandom_range(0, 7));
    if (r.action == vqdm_pkg::ACT_INIT && $urandom_range(0, 7) != 0) r.action = vqdm_pkg::ACT_POLL;
    r.entry_index = pick_index();
    r.buf_addr = {$urandom, $urandom};
    r.buf_len = $urandom;
    r.device_writes = 1'($urandom_range(0, 1));
    r.chained = 1'($urandom_range(0, 1));
    r.next_entry = 8'($urandom_range(0, 255));
    r.used_index = ($urandom_range(0, 1) != 0) ? used_ctr : 16'($urandom_range(0, 65535));
    send_request(r);
  endtask

  task automatic send_broken();
    request_t    r;
    logic [15:0] head;
    send_request(req_of(vqdm_pkg::ACT_ALLOC, 8'd0));
    head = shadow.last_got;
    if (shadow.qsize < vqdm_pkg::QUEUE_DEPTH) begin
      r = req_of(vqdm_pkg::ACT_FILL, 8'($urandom_range(shadow.qsize, 255)));
      r.buf_addr = {$urandom, $urandom};
      r.chained = 1'b1;
      send_request(r);
      send_request(req_of(vqdm_pkg::ACT_SUBMIT, 8'($urandom_range(shadow.qsize, 255))));
    end
    // Submit without a fill
    send_request(req_of(vqdm_pkg::ACT_SUBMIT, head[7:0]));
  endtask

  // Alloc a chain, fill it, publish the head, poll, then mostly give it back
  task automatic send_chain();
    logic [7:0]  chain [$];
    request_t    r;
    int unsigned k;
    k = $urandom_range(1, 4);
    repeat (k) begin
      send_request(req_of(vqdm_pkg::ACT_ALLOC, 8'd0));
      if (shadow.last_got != vqdm_pkg::LIST_END) chain.push_back(shadow.last_got[7:0]);
    end
    for (int i = 0; i < chain.size(); i++) begin
      r = req_of(vqdm_pkg::ACT_FILL, chain[i]);
      r.buf_addr = {$urandom, $urandom};
      r.buf_len = $urandom;
      r.device_writes = 1'($urandom_range(0, 1));
      r.chained = (i + 1 < chain.size());
      r.next_entry = r.chained ? chain[i + 1] : 8'($urandom_range(0, 255));
      send_request(r);
    end
    if (chain.size() > 0) send_request(req_of(vqdm_pkg::ACT_SUBMIT, chain[0]));
    used_ctr = used_ctr + 16'($urandom_range(0, 2));
    r = req_of(vqdm_pkg::ACT_POLL, 8'd0);
    r.used_index = used_ctr;
    send_request(r);
    if ($urandom_range(0, 3) != 0) begin
      while (chain.size() > 0) send_request(req_of(vqdm_pkg::ACT_FREE, chain.pop_back()));
    end
  endtask

  task automatic run_traffic(int unsigned target);
    int unsigned start;
    int unsigned pick;
    start = useful_requests;
    send_request(req_of(vqdm_pkg::ACT_INIT, 8'd0));
    while (useful_requests - start < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) send_chain();
      else if (pick < 9) send_noise();
      else send_broken();
    end
  endtask

  task automatic random_phase();
    logic [15:0] req;
    logic [15:0] dev;
    case ($urandom_range(0, 3))
      0: req = 16'($urandom_range(0, 65535));
      1: req = 16'(1 << $urandom_range(0, 8));
      2: req = 16'($urandom_range(1, 300));
      default: req = 16'($urandom_range(0, 8));
    endcase
    case ($urandom_range(0, 5))
      0: dev = 16'd0;
      1: dev = 16'hFFFF;
      2: dev = 16'd256;
      default: dev = 16'($urandom_range(1, 512));
    endcase
    drain();
    program_queue(req, dev, 16'($urandom_range(0, 65535)));
    run_traffic(130);
  endtask

  initial begin
    request_t r;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = '0;
    entry_index_i = '0;
    buf_addr_i = '0;
    buf_len_i = '0;
    device_writes_i = 1'b0;
    chained_i = 1'b0;
    next_entry_i = '0;
    used_index_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    running = 1'b1;
    @(negedge clk_i);

    // Before any init: empty free list, every index outside the queue
    send_request(req_of(vqdm_pkg::ACT_ALLOC, 8'd0));
    send_request(req_of(vqdm_pkg::ACT_FREE, 8'd0));
    send_request(req_of(vqdm_pkg::ACT_FILL, 8'd255));
    send_request(req_of(vqdm_pkg::ACT_SUBMIT, 8'd0));
    send_request(req_of(ACT_RSVD_6, 8'd0));
    // Full-size init writes every link entry before any alloc walks the list
    send_request(req_of(vqdm_pkg::ACT_INIT, 8'd0));
    send_request(req_of(vqdm_pkg::ACT_ALLOC, 8'd0));
    r = req_of(vqdm_pkg::ACT_FILL, 8'd0);
    r.buf_addr = '1;
    r.buf_len = '1;
    r.device_writes = 1'b1;
    r.chained = 1'b1;
    r.next_entry = 8'd255;
    send_request(r);
    send_request(req_of(vqdm_pkg::ACT_FILL, 8'd255));
    send_request(req_of(vqdm_pkg::ACT_SUBMIT, 8'd0));
    send_request(req_of(vqdm_pkg::ACT_SUBMIT, 8'd255));
    send_request(req_of(vqdm_pkg::ACT_FREE, 8'd255));
    send_request(req_of(vqdm_pkg::ACT_ALLOC, 8'd0));
    // Double free leaves a loop in the free list
    send_request(req_of(vqdm_pkg::ACT_FREE, 8'd7));
    send_request(req_of(vqdm_pkg::ACT_FREE, 8'd7));
    send_request(req_of(vqdm_pkg::ACT_ALLOC, 8'd0));
    send_request(req_of(vqdm_pkg::ACT_ALLOC, 8'd0));
    r = req_of(vqdm_pkg::ACT_POLL, 8'd0);
    r.used_index = 16'hFFFF;
    send_request(r);
    send_request(r);
    send_request(req_of(ACT_RSVD_7, 8'd0));
    send_request(req_of(vqdm_pkg::ACT_POLL, 8'd0));

    // Two-entry queue: run the free list dry, re-init
    drain();
    program_queue(16'd2, 16'hFFFF, 16'hFFFF);
    send_request(req_of(vqdm_pkg::ACT_INIT, 8'd0));
    repeat (3) send_request(req_of(vqdm_pkg::ACT_ALLOC, 8'd0));
    send_request(req_of(vqdm_pkg::ACT_SUBMIT, 8'd1));
    send_request(req_of(vqdm_pkg::ACT_SUBMIT, 8'd2));
    send_request(req_of(vqdm_pkg::ACT_INIT, 8'd0));

    // Device queue absent, then a zero size
    drain();
    program_queue(16'd256, 16'd0, 16'd1);
    send_request(req_of(vqdm_pkg::ACT_INIT, 8'd0));
    send_request(req_of(vqdm_pkg::ACT_ALLOC, 8'd0));
    drain();
    program_queue(16'd0, 16'd256, 16'd2);
    send_request(req_of(vqdm_pkg::ACT_INIT, 8'd0));

    // Size not a power of two rounds down
    drain();
    program_queue(16'd100, 16'd256, 16'($urandom_range(0, 65535)));
    run_traffic(130);

    // Largest request; receiver holds off while requests keep coming
    drain();
    program_queue(16'hFFFF, 16'hFFFF, 16'($urandom_range(0, 65535)));
    hold_req = 1'b1;
    run_traffic(150);

    // Device limits the queue to one entry
    drain();
    program_queue(16'd300, 16'd1, 16'($urandom_range(0, 65535)));
    run_traffic(60);

    repeat (7) random_phase();

    drain();
    repeat (300) @(negedge clk_i);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
